### rtl/core/tmc_pkg.sv
// ----------------------------------------------------------------------------
// tmc_pkg
// shared types, sizes and helpers of the tlp memory completer
// ----------------------------------------------------------------------------
package tmc_pkg;

	localparam int MEM_BYTES      = 65536;
	localparam int BOUNDARY_BYTES = 16384;
	localparam int WORDS          = MEM_BYTES / 4;
	localparam int BANK_DEPTH     = WORDS / 2;
	localparam int WORD_AW        = $clog2(WORDS);
	localparam int BANK_AW        = $clog2(BANK_DEPTH);
	localparam int BND_W          = $clog2(BOUNDARY_BYTES);
	localparam int CHUNK_W        = (BND_W + 1 > 12) ? BND_W + 1 : 12;

	localparam logic [31:0] CPL_HDR0   = 32'h4A00_0000;
	localparam logic [15:0] CID_RESET  = 16'd220;

	typedef struct packed {
		logic        mode;
		logic [31:0] packet_word;
	} tmc_in_t;

	typedef struct packed {
		logic [31:0] out_word;
		logic        word_valid;
		logic        is_header;
		logic        request_done;
		logic        batch_done;
		logic        overrun_seen;
	} tmc_out_t;

	typedef struct packed {
		tmc_out_t   res;
		logic       is_data;
		logic [3:0] keep;
		logic [1:0] shift;
	} tmc_meta_t;

	typedef struct packed {
		logic               wr_en;
		logic [WORD_AW-1:0] wr_idx;
		logic [3:0]         wr_be;
		logic [31:0]        wr_data;
		logic               rd_en;
		logic [WORD_AW-1:0] rd_idx;
	} tmc_mem_req_t;

	function automatic logic [2:0] ones4(input logic [3:0] v);
		ones4 = 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
	endfunction

endpackage

### rtl/core/tmc_store.sv
// ----------------------------------------------------------------------------
// tmc_store
// byte store as two word banks (even and odd words), cleared after reset
// ----------------------------------------------------------------------------
module tmc_store
	import tmc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  tmc_mem_req_t req,
	output logic         clearing,
	output logic [31:0]  rd_lo,
	output logic [31:0]  rd_hi
);

	logic [31:0] mem_even [BANK_DEPTH];
	logic [31:0] mem_odd  [BANK_DEPTH];

	logic               clearing_q;
	logic [BANK_AW-1:0] clr_cnt_q;
	logic [31:0]        even_q, odd_q;
	logic               sel_q;

	logic [WORD_AW-1:0] w1;
	logic [BANK_AW-1:0] even_ra, odd_ra, wa;
	logic               we_even, we_odd;
	logic [3:0]         wbe;
	logic [31:0]        wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == BANK_AW'(BANK_DEPTH - 1))
				clearing_q <= 1'b0;
		end
	end

	always_comb begin
		w1      = req.rd_idx + 1'b1;
		odd_ra  = req.rd_idx[WORD_AW-1:1];
		even_ra = req.rd_idx[0] ? w1[WORD_AW-1:1] : req.rd_idx[WORD_AW-1:1];
		if (clearing_q) begin
			wa      = clr_cnt_q;
			we_even = 1'b1;
			we_odd  = 1'b1;
			wbe     = 4'hF;
			wdata   = '0;
		end else begin
			wa      = req.wr_idx[WORD_AW-1:1];
			we_even = req.wr_en && !req.wr_idx[0];
			we_odd  = req.wr_en && req.wr_idx[0];
			wbe     = req.wr_be;
			wdata   = req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 4; j++) begin
			if (we_even && wbe[j])
				mem_even[wa][j*8 +: 8] <= wdata[j*8 +: 8];
			if (we_odd && wbe[j])
				mem_odd[wa][j*8 +: 8] <= wdata[j*8 +: 8];
		end
		if (req.rd_en) begin
			even_q <= mem_even[even_ra];
			odd_q  <= mem_odd[odd_ra];
			sel_q  <= req.rd_idx[0];
		end
	end

	assign clearing = clearing_q;
	assign rd_lo    = sel_q ? odd_q : even_q;
	assign rd_hi    = sel_q ? even_q : odd_q;

endmodule

### rtl/core/tmc_ctrl.sv
// ----------------------------------------------------------------------------
// tmc_ctrl
// request parser and completion sequencer
// ----------------------------------------------------------------------------
module tmc_ctrl
	import tmc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         accept,
	input  tmc_in_t      in_data,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	output tmc_mem_req_t mem_req,
	output tmc_meta_t    meta
);

	typedef enum logic [1:0] {PH_HDR, PH_ID, PH_ADDR, PH_DATA} phase_t;
	typedef enum logic [1:0] {EM_H0, EM_H1, EM_H2, EM_DATA} emit_t;

	phase_t      phase_q;
	emit_t       emit_q;
	logic        is_write_q, skip_q, rd_pend_q, end_pend_q, ovr_q;
	logic [9:0]  len_q, idx_q;
	logic [3:0]  fbe_q, lbe_q;
	logic [15:0] req_id_q, cid_q;
	logic [7:0]  tag_q;
	logic [31:0] wbase_q, ra_q;
	logic [11:0] bl_q, chunk_q;

	logic [31:0]        w, waddr, wb_next;
	logic [3:0]         be_sel;
	logic               w_in_range;
	logic [9:0]         idx_next;
	logic [CHUNK_W-1:0] bnd_left;
	logic [11:0]        chunk_sel, total;
	logic [2:0]         n;
	logic [12:0]        wcount;

	always_comb begin
		w        = in_data.packet_word;
		be_sel   = (idx_q == '0) ? fbe_q : (idx_q == len_q - 1'b1) ? lbe_q : 4'hF;
		waddr    = wbase_q + {20'b0, idx_q, 2'b00};
		w_in_range = waddr < 32'(MEM_BYTES);
		idx_next = idx_q + 1'b1;
		wb_next  = {w[31:2], 2'b00};
		bnd_left = CHUNK_W'(BOUNDARY_BYTES) - CHUNK_W'(ra_q[BND_W-1:0]);
		chunk_sel = (bnd_left > CHUNK_W'(bl_q)) ? bl_q : 12'(bnd_left);
		wcount   = ({1'b0, chunk_sel} + 13'd3) >> 2;
		n        = (chunk_q < 12'd4) ? chunk_q[2:0] : 3'd4;
		if (len_q == '0)
			total = '0;
		else if (len_q == 10'd1)
			total = 12'(ones4(fbe_q));
		else
			total = {len_q, 2'b00} - 12'd8 + 12'(ones4(fbe_q)) + 12'(ones4(lbe_q));
	end

	always_comb begin
		mem_req         = '0;
		mem_req.wr_en   = accept && !in_data.mode && phase_q == PH_DATA && !skip_q && w_in_range;
		mem_req.wr_idx  = waddr[WORD_AW+1:2];
		mem_req.wr_be   = be_sel;
		mem_req.wr_data = w;
		mem_req.rd_en   = accept && in_data.mode && rd_pend_q && emit_q == EM_DATA;
		mem_req.rd_idx  = ra_q[WORD_AW+1:2];

		meta                  = '0;
		meta.res.overrun_seen = ovr_q;
		meta.shift            = ra_q[1:0];
		for (int j = 0; j < 4; j++)
			meta.keep[j] = (3'(j) < n) && ((ra_q + 32'(j)) < 32'(MEM_BYTES));
		if (rd_pend_q) begin
			meta.res.word_valid = 1'b1;
			unique case (emit_q)
				EM_H0: begin
					meta.res.out_word  = CPL_HDR0 | {22'b0, wcount[9:0]};
					meta.res.is_header = 1'b1;
				end
				EM_H1: begin
					meta.res.out_word  = {cid_q, 4'b0, bl_q};
					meta.res.is_header = 1'b1;
				end
				EM_H2: begin
					meta.res.out_word  = {req_id_q, tag_q, 1'b0, ra_q[6:0]};
					meta.res.is_header = 1'b1;
				end
				EM_DATA: begin
					meta.is_data          = 1'b1;
					meta.res.request_done = (chunk_q == 12'(n)) && (bl_q == 12'(n));
				end
				default: ;
			endcase
		end else if (end_pend_q) begin
			meta.res.word_valid = 1'b1;
			meta.res.batch_done = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR;
			emit_q     <= EM_H0;
			is_write_q <= 1'b0;
			skip_q     <= 1'b0;
			rd_pend_q  <= 1'b0;
			end_pend_q <= 1'b0;
			ovr_q      <= 1'b0;
			len_q      <= '0;
			idx_q      <= '0;
			fbe_q      <= '0;
			lbe_q      <= '0;
			req_id_q   <= '0;
			cid_q      <= CID_RESET;
			tag_q      <= '0;
			wbase_q    <= '0;
			ra_q       <= '0;
			bl_q       <= '0;
			chunk_q    <= '0;
		end else begin
			if (cfg_we)
				cid_q <= cfg_wdata;
			if (accept && !in_data.mode) begin
				unique case (phase_q)
					PH_HDR: begin
						if (w[31]) begin
							end_pend_q <= 1'b1;
						end else begin
							is_write_q <= w[30];
							len_q      <= w[9:0];
							phase_q    <= PH_ID;
						end
					end
					PH_ID: begin
						req_id_q <= w[31:16];
						tag_q    <= w[15:8];
						lbe_q    <= w[7:4];
						fbe_q    <= w[3:0];
						phase_q  <= PH_ADDR;
					end
					PH_ADDR: begin
						if (is_write_q) begin
							wbase_q <= wb_next;
							skip_q  <= wb_next >= 32'(MEM_BYTES);
							idx_q   <= '0;
							phase_q <= (len_q == '0) ? PH_HDR : PH_DATA;
						end else begin
							phase_q <= PH_HDR;
							if (rd_pend_q || end_pend_q) begin
								ovr_q <= 1'b1;
							end else if (total != '0) begin
								ra_q      <= w;
								bl_q      <= total;
								chunk_q   <= '0;
								emit_q    <= EM_H0;
								rd_pend_q <= 1'b1;
							end
						end
					end
					PH_DATA: begin
						idx_q <= idx_next;
						if (idx_next >= len_q)
							phase_q <= PH_HDR;
					end
					default: ;
				endcase
			end
			if (accept && in_data.mode) begin
				if (rd_pend_q) begin
					unique case (emit_q)
						EM_H0: begin
							chunk_q <= chunk_sel;
							emit_q  <= EM_H1;
						end
						EM_H1: emit_q <= EM_H2;
						EM_H2: emit_q <= EM_DATA;
						EM_DATA: begin
							ra_q    <= ra_q + 32'(n);
							bl_q    <= bl_q - 12'(n);
							chunk_q <= chunk_q - 12'(n);
							if (chunk_q == 12'(n)) begin
								emit_q <= EM_H0;
								if (bl_q == 12'(n))
									rd_pend_q <= 1'b0;
							end
						end
						default: ;
					endcase
				end else if (end_pend_q) begin
					end_pend_q <= 1'b0;
				end
			end
		end
	end

endmodule

### rtl/core/tlp_memory_completer.sv
// ----------------------------------------------------------------------------
// tlp_memory_completer
// memory completer for a stream of 32-bit request words
// ----------------------------------------------------------------------------
// input channel (in_valid / in_stall / in_data): mode 0 carries one request
// word (write or read headers, write payload), mode 1 pulls one completion
// word. every pull gives exactly one output request on out_valid / out_stall /
// out_data; request words give none.
// one input request is taken per cycle, back to back, while in_stall is low.
// an accepted pull is registered first by the synchronous read of the byte
// store, then by the output register.
// the byte store is two banks of 32-bit words (even and odd words), so an
// unaligned four-byte read needs one access per bank in the same cycle.
// after reset the store is zeroed one bank row per cycle while
// in_stall stays high; completer id writes on cfg_we are taken at any time.
// when the receiver holds out_stall, the output and one pull behind it, if any,
// are held, and in_stall rises while that pull waits, until the output moves.
// ----------------------------------------------------------------------------
module tlp_memory_completer
	import tmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  tmc_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output tmc_out_t    out_data,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	tmc_mem_req_t mem_req;
	tmc_meta_t    meta, meta_s1;
	logic         clearing, accept, s1_valid_s1, s1_adv, out_valid_q;
	logic [31:0]  rd_lo, rd_hi, data_word;
	logic [63:0]  pair;
	tmc_out_t     res_s1, out_q;

	assign s1_adv   = s1_valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = clearing || (s1_valid_s1 && out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	tmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.mem_req   (mem_req),
		.meta      (meta)
	);

	tmc_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mem_req),
		.clearing (clearing),
		.rd_lo    (rd_lo),
		.rd_hi    (rd_hi)
	);

	always_comb begin
		pair = {rd_hi, rd_lo} >> {meta_s1.shift, 3'b000};
		for (int j = 0; j < 4; j++)
			data_word[j*8 +: 8] = meta_s1.keep[j] ? pair[j*8 +: 8] : 8'h00;
		res_s1 = meta_s1.res;
		if (meta_s1.is_data)
			res_s1.out_word = data_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && in_data.mode)
				s1_valid_s1 <= 1'b1;
			else if (s1_adv)
				s1_valid_s1 <= 1'b0;
			if (s1_adv)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_data.mode)
			meta_s1 <= meta;
		if (s1_adv)
			out_q <= res_s1;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_clear_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> in_stall)
		else $error("input taken during store clear");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && out_valid_q && out_stall |=> s1_valid_s1)
		else $error("pending pull lost while output stalled");

	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.batch_done |-> out_data.out_word == 32'h0
			&& !out_data.is_header && !out_data.request_done)
		else $error("batch terminator not a plain zero word");

	a_no_read_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.wr_en && mem_req.rd_en))
		else $error("store read and write in one cycle");

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the tlp memory completer against a cycle-free prediction of its
// request parsing, byte store, read splitting and completion output
// ----------------------------------------------------------------------------
module tb;
	import tmc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;
	localparam logic [1:0] PH_HDR     = 2'd0;
	localparam logic [1:0] PH_ID      = 2'd1;
	localparam logic [1:0] PH_ADDR    = 2'd2;
	localparam logic [1:0] PH_DATA    = 2'd3;
	localparam logic       MODE_WORD  = 1'b0;
	localparam logic       MODE_PULL  = 1'b1;
	localparam int         LIMIT      = 1500000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	tmc_in_t     in_data;
	logic        out_valid;
	logic        out_stall;
	tmc_out_t    out_data;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	tlp_memory_completer u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// predicted state
	logic [7:0]  mem_img [MEM_BYTES];
	logic [15:0] cid;
	logic [1:0]  p_phase, p_kind, e_phase;
	logic [9:0]  p_len, p_idx;
	logic [3:0]  p_fbe, p_lbe;
	logic [15:0] p_req;
	logic [7:0]  p_tag;
	logic [31:0] p_base, r_addr;
	logic        p_skip, r_pend, end_pend, ovr;
	int unsigned r_left, r_chunk;

	tmc_out_t    cpl_q[$];
	int          errors;
	int          pulls;
	int          sent_items;
	int          cycles;
	bit          idle_ok;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
		$display("mismatch %s: got %h expected %h", what, got, exp);
		errors++;
	endtask

	function automatic int unsigned popc(input logic [3:0] v);
		return v[0] + v[1] + v[2] + v[3];
	endfunction

	function automatic void predict_reset();
		foreach (mem_img[i]) mem_img[i] = 8'h00;
		cid = CID_RESET;
		p_phase = PH_HDR; p_kind = 0; p_len = 0; p_idx = 0; p_fbe = 0; p_lbe = 0;
		p_req = 0; p_tag = 0; p_base = 0; p_skip = 0; r_addr = 0; r_left = 0;
		r_chunk = 0; e_phase = 0; r_pend = 0; end_pend = 0; ovr = 0;
	endfunction

	function automatic void predict_word(input logic [31:0] w);
		int unsigned total;
		logic [3:0]  be;
		longint      a;
		case (p_phase)
			PH_HDR: begin
				if (w[31:30] > KIND_WRITE) end_pend = 1;
				else begin
					p_kind = w[31:30];
					p_len = w[9:0];
					p_phase = PH_ID;
				end
			end
			PH_ID: begin
				p_req = w[31:16]; p_tag = w[15:8]; p_lbe = w[7:4]; p_fbe = w[3:0];
				p_phase = PH_ADDR;
			end
			PH_ADDR: begin
				if (p_kind == KIND_WRITE) begin
					p_base = {w[31:2], 2'b00};
					p_skip = p_base >= MEM_BYTES;
					p_idx = 0;
					p_phase = (p_len == 0) ? PH_HDR : PH_DATA;
				end else begin
					p_phase = PH_HDR;
					if (p_len == 0) total = 0;
					else if (p_len == 1) total = popc(p_fbe);
					else total = p_len * 4 - (4 - popc(p_fbe)) - (4 - popc(p_lbe));
					if (r_pend || end_pend) ovr = 1;
					else if (total != 0) begin
						r_addr = w; r_left = total; r_chunk = 0; e_phase = 0; r_pend = 1;
					end
				end
			end
			default: begin
				be = (p_idx == 0) ? p_fbe : (p_idx == p_len - 1) ? p_lbe : 4'hF;
				if (!p_skip)
					for (int j = 0; j < 4; j++) begin
						a = longint'(p_base) + p_idx * 4 + j;
						if (be[j] && a < MEM_BYTES) mem_img[a] = w[j*8 +: 8];
					end
				p_idx = p_idx + 1;
				if (p_idx >= p_len) p_phase = PH_HDR;
			end
		endcase
	endfunction

	function automatic tmc_out_t predict_pull();
		tmc_out_t    r;
		int unsigned n;
		logic [31:0] a;
		r = '0;
		if (r_pend) begin
			r.word_valid = 1;
			case (e_phase)
				2'd0: begin
					r_chunk = BOUNDARY_BYTES - (r_addr % BOUNDARY_BYTES);
					if (r_chunk > r_left) r_chunk = r_left;
					r.out_word = CPL_HDR0 | ((r_chunk + 3) / 4);
					r.is_header = 1; e_phase = 1;
				end
				2'd1: begin
					r.out_word = {cid, 16'(r_left)};
					r.is_header = 1; e_phase = 2;
				end
				2'd2: begin
					r.out_word = {p_req, p_tag, 1'b0, r_addr[6:0]};
					r.is_header = 1; e_phase = 3;
				end
				default: begin
					n = r_chunk < 4 ? r_chunk : 4;
					for (int j = 0; j < n; j++) begin
						a = r_addr + j;
						if (a < MEM_BYTES) r.out_word[j*8 +: 8] = mem_img[a];
					end
					r_addr += n; r_left -= n; r_chunk -= n;
					if (r_chunk == 0) begin
						e_phase = 0;
						if (r_left == 0) begin
							r.request_done = 1; r_pend = 0;
						end
					end
				end
			endcase
		end else if (end_pend) begin
			r.word_valid = 1; r.batch_done = 1; end_pend = 0;
		end
		r.overrun_seen = ovr;
		return r;
	endfunction

	// in_valid stays high between back-to-back requests and drops only for idling
	task automatic send(input logic mode, input logic [31:0] w);
		if (idle_ok && $urandom_range(0, 7) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= '{mode: mode, packet_word: w};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_items++;
		if (mode == MODE_PULL) begin
			cpl_q.push_back(predict_pull());
			pulls++;
		end else predict_word(w);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 0;
		while (cpl_q.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic set_cid(input logic [15:0] v);
		drain();
		cfg_we <= 1; cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		cid = v;
	endtask

	// one whole packet: header, then id word and address for reads and writes, then payload for writes
	task automatic send_packet(input logic [1:0] kind, input logic [9:0] len,
		input logic [3:0] fbe, input logic [3:0] lbe, input logic [31:0] addr);
		send(MODE_WORD, {kind, 20'($urandom), len});
		if (kind > KIND_WRITE) return;
		send(MODE_WORD, {16'($urandom), 8'($urandom), lbe, fbe});
		send(MODE_WORD, addr);
		if (kind == KIND_WRITE)
			for (int i = 0; i < len; i++) send(MODE_WORD, $urandom);
	endtask

	task automatic pull_all();
		int k;
		k = 0;
		while ((r_pend || end_pend) && k < 5000) begin
			send(MODE_PULL, $urandom);
			k++;
		end
		send(MODE_PULL, $urandom);
	endtask

	always @(posedge clk) begin
		tmc_out_t e;
		if (out_valid && !out_stall) begin
			if (cpl_q.size() == 0) report("unexpected output", out_data.out_word, 0);
			else begin
				e = cpl_q.pop_front();
				if (out_data.out_word !== e.out_word) report("out_word", out_data.out_word, e.out_word);
				if (out_data.word_valid !== e.word_valid) report("word_valid", out_data.word_valid, e.word_valid);
				if (out_data.is_header !== e.is_header) report("is_header", out_data.is_header, e.is_header);
				if (out_data.request_done !== e.request_done)
					report("request_done", out_data.request_done, e.request_done);
				if (out_data.batch_done !== e.batch_done) report("batch_done", out_data.batch_done, e.batch_done);
				if (out_data.overrun_seen !== e.overrun_seen)
					report("overrun_seen", out_data.overrun_seen, e.overrun_seen);
			end
		end
	end

	always @(posedge clk) begin
		if (!idle_ok) out_stall <= 0;
		else if ($urandom_range(0, 9) == 0) begin
			out_stall <= 1;
			repeat ($urandom_range(1, 15)) @(posedge clk);
			out_stall <= 0;
		end
	end

	task automatic test_directed();
		pull_all();
		send_packet(KIND_WRITE, 3, 4'hF, 4'hF, 32'h0000_0100);
		send_packet(KIND_READ, 3, 4'hF, 4'hF, 32'h0000_0100);
		pull_all();
		send_packet(KIND_WRITE, 2, 4'h6, 4'h1, 32'h0000_0203);
		send_packet(KIND_READ, 2, 4'hE, 4'h7, 32'h0000_0201);
		pull_all();
		send_packet(KIND_READ, 1, 4'h5, 4'h0, 32'h0000_0100);
		pull_all();
		send_packet(KIND_WRITE, 4, 4'hF, 4'hF, 32'h0000_FFF8);
		send_packet(KIND_WRITE, 1, 4'hF, 4'hF, 32'hFFFF_FFFC);
		send_packet(KIND_READ, 4, 4'hF, 4'hF, 32'h0000_FFFA);
		pull_all();
		send_packet(KIND_READ, 2, 4'hF, 4'hF, 32'hFFFF_FFFE);
		pull_all();
		send_packet(KIND_READ, 0, 4'hF, 4'hF, 32'h10);
		send_packet(KIND_READ, 1, 4'h0, 4'h0, 32'h10);
		send_packet(KIND_WRITE, 0, 4'hF, 4'hF, 32'h10);
		send_packet(KIND_READ, 6, 4'hF, 4'hF, 32'h0000_3FF6);
		send_packet(KIND_READ, 1, 4'hF, 4'hF, 32'h0);
		send_packet(2'd3, 0, 0, 0, 0);
		send_packet(KIND_END, 0, 0, 0, 0);
		pull_all();
		send_packet(KIND_READ, 10'h3FF, 4'hF, 4'hF, 32'h0000_3F00);
		pull_all();
	endtask

	task automatic test_config();
		set_cid(16'h0000);
		send_packet(KIND_READ, 1, 4'hF, 4'hF, 32'h40);
		pull_all();
		set_cid(16'hFFFF);
		send_packet(KIND_READ, 1, 4'hF, 4'hF, 32'h40);
		pull_all();
		set_cid(16'($urandom));
	endtask

	task automatic test_random(input int n_items);
		logic [31:0] addr;
		logic [9:0]  len;
		int          stop;
		stop = sent_items + n_items;
		while (sent_items < stop) begin
			len = ($urandom_range(0, 15) == 0) ? 10'($urandom) : 10'($urandom_range(0, 6));
			addr = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, MEM_BYTES + 64));
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send_packet(KIND_WRITE, len, 4'($urandom), 4'($urandom), addr);
				4, 5, 6: send_packet(KIND_READ, len % 12, 4'($urandom), 4'($urandom), addr);
				7: send(MODE_WORD, $urandom);
				8: send_packet(KIND_END, 0, 0, 0, 0);
				default: repeat ($urandom_range(1, 6)) send(MODE_PULL, $urandom);
			endcase
			if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 30)) send(MODE_PULL, $urandom);
		end
		pull_all();
	endtask

	initial begin
		errors = 0; pulls = 0; sent_items = 0; cycles = 0; idle_ok = 0;
		arst_n = 0; in_valid = 0; in_data = '0; cfg_we = 0; cfg_wdata = 0; out_stall = 0;
		predict_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		idle_ok = 1;
		test_directed();
		test_config();
		test_random(250);
		idle_ok = 0;
		test_random(100);
		drain();
		if (cpl_q.size() != 0) report("missing outputs", cpl_q.size(), 0);
		$display("checked %0d pulled completion words over writes, reads, terminators and",
			pulls);
		$display("out-of-range, boundary-split and overlapping reads under random stalls");
		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule

### tlp_memory_completer.f
rtl/core/tmc_pkg.sv
rtl/core/tmc_store.sv
rtl/core/tmc_ctrl.sv
rtl/core/tlp_memory_completer.sv
verif/tb.sv
